// ===== rtl/core/ptt_pkg.sv =====
// shared types, codes and constants of the pdo trigger timer table
`timescale 1ns / 1ps
`default_nettype none
package ptt_pkg;

  localparam int RX_ENTRIES = 8;
  localparam int TX_ENTRIES = 8;
  localparam int ENT_AW     = 3;
  localparam int ADDR_W     = ENT_AW + 1;
  localparam int DEPTH      = 2 ** ADDR_W;
  localparam int NUM_W      = 26;
  localparam int DEN_W      = 16;
  localparam int CNT_W      = 5;

  // function codes
  localparam logic [2:0] FN_TICK    = 3'd0;
  localparam logic [2:0] FN_LOAD    = 3'd1;
  localparam logic [2:0] FN_RESTART = 3'd2;
  localparam logic [2:0] FN_SYNC    = 3'd3;
  localparam logic [2:0] FN_INHIBIT = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_STATUS     = 2'd0;
  localparam logic [1:0] KIND_RX_TIMEOUT = 2'd1;
  localparam logic [1:0] KIND_TX_EVENT   = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_NO_OBJECT     = 3'd1;
  localparam logic [2:0] ST_INVALID       = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE      = 3'd3;
  localparam logic [2:0] ST_NOT_TRIGGERED = 3'd4;
  localparam logic [2:0] ST_INHIBITED     = 3'd5;

  localparam logic [7:0]       TT_EVENT_MIN = 8'd254;
  localparam logic [7:0]       TT_SYNC_MAX  = 8'd240;
  localparam logic [NUM_W-1:0] MS_TO_US     = NUM_W'(1000);
  localparam logic [NUM_W-1:0] INH_TO_US    = NUM_W'(100);
  localparam logic [15:0]      TICK_RESET   = 16'd1000;

  typedef struct packed {
    logic        valid;
    logic [7:0]  trans_type;
    logic [15:0] event_ms;
    logic [15:0] inhibit_time;
    logic [7:0]  sync_start;
    logic        resync;
    logic [7:0]  sync_count;
    logic [22:0] inhibit_count;
    logic [27:0] event_count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_RESET = '{
    valid: 1'b0, trans_type: 8'd0, event_ms: 16'd0, inhibit_time: 16'd0,
    sync_start: 8'd0, resync: 1'b1, sync_count: 8'd0, inhibit_count: 23'd0,
    event_count: 28'd0
  };

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EVAL, S_MUL, S_DIV, S_WRITE, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    RL_NONE, RL_RX, RL_TX, RL_INH
  } reload_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/ptt_ram.sv =====
// generic single-port-write, registered-read entry memory
`timescale 1ns / 1ps
`default_nettype none
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/ptt_div.sv =====
// bit-serial restoring divider for counter reloads
`timescale 1ns / 1ps
`default_nettype none
module ptt_div
  import ptt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  input  logic [DEN_W-1:0] den,
  output div_rsp_t         rsp
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] quot;
  logic [DEN_W:0]   rem;
  logic [DEN_W:0]   rem_sh;
  logic             fits;
  logic             done;

  assign rem_sh = {rem[DEN_W-1:0], quot[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.num;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[NUM_W-2:0], fits};
      rem  <= fits ? (rem_sh - {1'b0, den}) : rem_sh;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule
`default_nettype wire

// ===== rtl/core/pdo_trigger_timer_table.sv =====
// top level of the pdo trigger timer table: sequencer, entry memory, divider
// usage:
//   input channel (in_valid/in_stall) takes one request with a function code:
//   tick, load entry, restart event timer, sync test or inhibit test
//   output channel (out_valid/out_stall) returns results; each request ends
//   with a result that has last set
//   a command gives one status result; a tick walks all receive then all
//   transmit entries and gives one timeout/transmit event per expired
//   counter, then a done result
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the tick period in us;
//   it is ready out of reset and is meant to be written while the block is idle
// sequence:
//   one entry of a tick walk costs a read, an update and a write back,
//   plus an emit step when it reports an event
//   a counter reload adds a multiply and a bit-serial divide
//   a rejected command skips the entry read and goes straight to its result
//   the request is held off (in_stall) until its last result is registered
// reset: tick period 1000 us, entries read as their reset value (no clearing pass),
//   in_stall high and cfg_ready low while rst is high
// a stalled receiver freezes the sequencer at its next result; one finished
// result waits in the output register while the next entry is worked on
`timescale 1ns / 1ps
`default_nettype none
module pdo_trigger_timer_table
  import ptt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic        is_transmit,
  input  logic [3:0]  entry,
  input  logic [7:0]  sync_counter,
  input  logic        load_valid,
  input  logic [7:0]  load_trans_type,
  input  logic [15:0] load_event_ms,
  input  logic [15:0] load_inhibit_100us,
  input  logic [7:0]  load_sync_start,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic        is_transmit_res,
  output logic [3:0]  entry_out,
  output logic [2:0]  status,
  output logic        last,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  state_t state, state_next;

  // latched request
  logic        r_tick;
  logic [2:0]  r_func;
  logic        r_tx;
  logic [7:0]  r_sc;
  logic        r_lvalid;
  logic [7:0]  r_ltt;
  logic [15:0] r_lms;
  logic [15:0] r_linh;
  logic [7:0]  r_lss;

  logic [15:0]       tick_period;
  logic [DEN_W-1:0]  den;
  logic [ADDR_W-1:0] idx;
  logic [DEPTH-1:0]  written;
  entry_t            w;
  reload_t           rl;
  logic              emit;
  logic              fin;

  // pending result
  logic [1:0] res_kind;
  logic       res_tx;
  logic [3:0] res_ent;
  logic [2:0] res_st;
  logic       res_last;

  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             cur;
  logic               in_acc;
  logic               bad_cmd;
  logic               out_free;
  logic               tick_end;
  logic [NUM_W-1:0]   prod;
  logic               div_start;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // eval results
  entry_t     e;
  reload_t    e_rl;
  logic [2:0] e_st;
  logic       e_emit;
  logic [7:0] sync_cnt;

  assign cfg_ready = !rst;
  assign den       = (tick_period == 16'd0) ? 16'd1 : tick_period;
  assign in_stall  = rst || (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign bad_cmd   = (func > FN_INHIBIT)
                     || (is_transmit ? (entry >= 4'(TX_ENTRIES)) : (entry >= 4'(RX_ENTRIES)))
                     || (((func == FN_SYNC) || (func == FN_INHIBIT)) && !is_transmit);

  // last entry of a tick walk
  assign tick_end = idx[ENT_AW] ? (idx[ENT_AW-1:0] == ENT_AW'(TX_ENTRIES - 1))
                                : 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= TICK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tick_period <= cfg_data;
    end
  end

  ptt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH),
    .AW   (ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (state == S_WRITE),
    .waddr(idx),
    .wdata(w),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  // never-written entries read as their reset value
  assign cur = written[idx] ? entry_t'(ram_rdata) : ENTRY_RESET;

  assign div_req.start = div_start;
  assign div_req.num   = prod;

  ptt_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .den(den),
    .rsp(div_rsp)
  );

  // entry update
  always_comb begin
    e        = cur;
    e_rl     = RL_NONE;
    e_st     = ST_OK;
    e_emit   = 1'b0;
    sync_cnt = 8'd0;
    if (r_tick) begin
      if (!idx[ENT_AW]) begin
        if (e.event_count != 28'd0) begin
          e.event_count = e.event_count - 28'd1;
          if (e.event_count == 28'd0) begin
            e_emit = 1'b1;
            if (e.valid && (e.event_ms != 16'd0)) begin
              e_rl = RL_RX;
            end
          end
        end
      end else begin
        if (e.inhibit_count != 23'd0) begin
          e.inhibit_count = e.inhibit_count - 23'd1;
        end
        if (e.event_count != 28'd0) begin
          e.event_count = e.event_count - 28'd1;
          if (e.event_count == 28'd0) begin
            e_emit = 1'b1;
            if (e.valid && (e.trans_type >= TT_EVENT_MIN) && (e.event_ms != 16'd0)) begin
              e_rl = RL_TX;
            end
          end
        end
      end
    end else begin
      case (r_func)
        FN_LOAD: begin
          e.valid      = r_lvalid;
          e.trans_type = r_ltt;
          e.event_ms   = r_lms;
          e.event_count = 28'd0;
          if (r_tx) begin
            e.inhibit_time = r_linh;
            e.sync_start   = r_lss;
            e.resync       = 1'b1;
            if (r_lvalid && (r_ltt >= TT_EVENT_MIN) && (r_lms != 16'd0)) begin
              e_rl = RL_TX;
            end
          end
        end
        FN_RESTART: begin
          e.event_count = 28'd0;
          if (r_tx) begin
            if (e.valid && (e.trans_type >= TT_EVENT_MIN) && (e.event_ms != 16'd0)) begin
              e_rl = RL_TX;
            end
          end else if (e.valid && (e.event_ms != 16'd0)) begin
            e_rl = RL_RX;
          end
        end
        FN_SYNC: begin
          if (!e.valid) begin
            e_st = ST_INVALID;
          end else if ((e.trans_type == 8'd0) || (e.trans_type > TT_SYNC_MAX)) begin
            e_st = ST_BAD_TYPE;
          end else if (e.resync && (e.sync_start != 8'd0) && (r_sc != 8'd0)
                       && (e.sync_start != r_sc)) begin
            e_st = ST_NOT_TRIGGERED;
          end else begin
            sync_cnt = (e.resync ? e.trans_type : e.sync_count) - 8'd1;
            e.resync = 1'b0;
            if (sync_cnt != 8'd0) begin
              e.sync_count = sync_cnt;
              e_st         = ST_NOT_TRIGGERED;
            end else begin
              e.sync_count = e.trans_type;
            end
          end
        end
        FN_INHIBIT: begin
          if (!e.valid) begin
            e_st = ST_INVALID;
          end else if (e.trans_type >= TT_EVENT_MIN) begin
            if (e.inhibit_count != 23'd0) begin
              e_st = ST_INHIBITED;
            end else begin
              e_rl = RL_INH;
            end
          end
        end
        default: begin
          e_st = ST_NO_OBJECT;
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = (func != FN_TICK && bad_cmd) ? S_EMIT : S_READ;
        end
      end
      S_READ: state_next = S_EVAL;
      S_EVAL: state_next = (e_rl == RL_NONE) ? S_WRITE : S_MUL;
      S_MUL:  state_next = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if (emit || !r_tick || tick_end) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_READ;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          if (fin) begin
            state_next = S_IDLE;
          end else if (tick_end) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_READ;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= (state == S_MUL);
      if (state == S_WRITE) begin
        written[idx] <= 1'b1;
      end
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      r_tick   <= (func == FN_TICK);
      r_func   <= func;
      r_tx     <= is_transmit;
      r_sc     <= sync_counter;
      r_lvalid <= load_valid;
      r_ltt    <= load_trans_type;
      r_lms    <= load_event_ms;
      r_linh   <= load_inhibit_100us;
      r_lss    <= load_sync_start;
      idx      <= (func == FN_TICK) ? '0 : {is_transmit, entry[ENT_AW-1:0]};
      res_kind <= KIND_STATUS;
      res_tx   <= is_transmit;
      res_ent  <= entry;
      res_st   <= ST_NO_OBJECT;
      res_last <= 1'b1;
      fin      <= 1'b1;
    end
    if (state == S_EVAL) begin
      w    <= e;
      rl   <= e_rl;
      emit <= e_emit;
      if (r_tick) begin
        res_kind <= idx[ENT_AW] ? KIND_TX_EVENT : KIND_RX_TIMEOUT;
        res_tx   <= idx[ENT_AW];
        res_ent  <= {1'b0, idx[ENT_AW-1:0]};
        res_st   <= ST_OK;
        res_last <= 1'b0;
        fin      <= 1'b0;
      end else begin
        res_st <= e_st;
      end
    end
    if (state == S_MUL) begin
      prod <= (rl == RL_INH) ? ({{(NUM_W-16){1'b0}}, w.inhibit_time} * INH_TO_US)
                             : ({{(NUM_W-16){1'b0}}, w.event_ms} * MS_TO_US);
    end
    if (state == S_DIV && div_rsp.done) begin
      case (rl)
        RL_RX:   w.event_count <= {2'b00, div_rsp.quot} + 28'd1;
        RL_TX:   w.event_count <= (div_rsp.quot == '0) ? 28'd1 : {2'b00, div_rsp.quot};
        RL_INH:  w.inhibit_count <= div_rsp.quot[22:0];
        default: w.event_count <= w.event_count;
      endcase
    end
    // tick walk: advance or close with the done result
    if ((state == S_WRITE && r_tick && !emit && tick_end)
        || (state == S_EMIT && out_free && !fin && tick_end)) begin
      res_kind <= KIND_STATUS;
      res_tx   <= 1'b0;
      res_ent  <= 4'd0;
      res_st   <= ST_OK;
      res_last <= 1'b1;
      fin      <= 1'b1;
    end
    if ((state == S_WRITE && r_tick && !emit && !tick_end)
        || (state == S_EMIT && out_free && !fin && !tick_end)) begin
      if (!idx[ENT_AW] && (idx[ENT_AW-1:0] == ENT_AW'(RX_ENTRIES - 1))) begin
        idx <= {1'b1, {ENT_AW{1'b0}}};
      end else begin
        idx <= idx + ADDR_W'(1);
      end
    end
    if (state == S_EMIT && out_free) begin
      kind            <= res_kind;
      is_transmit_res <= res_tx;
      entry_out       <= res_ent;
      status          <= res_st;
      last            <= res_last;
    end
  end

  // divider completes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divider done outside wait state");

  // an accepted request always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state != S_IDLE)
    else $error("request accepted but sequencer idle");

  // the final result returns the sequencer to idle
  a_fin_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free && fin) |=> (state == S_IDLE && out_valid && last))
    else $error("final result did not close the request");

  // written marks only accumulate
  a_written_grows: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> $countones(written) >= $countones($past(written)))
    else $error("written mark lost");

endmodule
`default_nettype wire

// ===== test/pdo_trigger_timer_table_tb.sv =====
// testbench of the pdo trigger timer table: directed and random requests against a predictor
`timescale 1ns / 1ps
`default_nettype none
module pdo_trigger_timer_table_tb
  import ptt_pkg::*;
();

  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  func = FN_TICK;
  logic        is_transmit = 1'b0;
  logic [3:0]  entry = '0;
  logic [7:0]  sync_counter = '0;
  logic        load_valid = 1'b0;
  logic [7:0]  load_trans_type = '0;
  logic [15:0] load_event_ms = '0;
  logic [15:0] load_inhibit_100us = '0;
  logic [7:0]  load_sync_start = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic        is_transmit_res;
  logic [3:0]  entry_out;
  logic [2:0]  status;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  pdo_trigger_timer_table DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .is_transmit(is_transmit),
    .entry(entry), .sync_counter(sync_counter), .load_valid(load_valid),
    .load_trans_type(load_trans_type), .load_event_ms(load_event_ms),
    .load_inhibit_100us(load_inhibit_100us), .load_sync_start(load_sync_start),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .is_transmit_res(is_transmit_res), .entry_out(entry_out), .status(status),
    .last(last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // one expected result
  typedef struct packed {
    logic [1:0] kind;
    logic       tx;
    logic [3:0] ent;
    logic [2:0] st;
    logic       last;
  } result_t;

  result_t pending_results[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  bit      hold_off = 1'b0;
  bit      burst_mode = 1'b1;

  // predictor state: one table of each kind, sized for the full entry field
  logic [15:0] tick_us;
  entry_t      rx_tab[16];
  entry_t      tx_tab[16];

  function automatic logic [27:0] event_reload(entry_t e, bit tx_side);
    logic [31:0] q;
    logic [31:0] d;
    d = (tick_us == 0) ? 32'd1 : {16'd0, tick_us};
    q = (32'(e.event_ms) * 32'd1000) / d;
    if (!e.valid || e.event_ms == 0) return '0;
    if (tx_side) begin
      if (e.trans_type < TT_EVENT_MIN) return '0;
      return (q == 0) ? 28'd1 : q[27:0];
    end
    return q[27:0] + 28'd1;
  endfunction

  // works out the results of one request and updates the predictor tables
  task automatic predict_request(input logic [2:0] fn, input logic tx, input logic [3:0] ent,
                                 input logic [7:0] sc, input logic lv, input logic [7:0] ltt,
                                 input logic [15:0] lev, input logic [15:0] linh,
                                 input logic [7:0] lss);
    logic [2:0]  st;
    logic [31:0] d;
    bit          present;
    st = ST_OK;
    d = (tick_us == 0) ? 32'd1 : {16'd0, tick_us};
    present = tx ? (ent < TX_ENTRIES) : (ent < RX_ENTRIES);
    if (fn == FN_TICK) begin
      for (int i = 0; i < RX_ENTRIES; i++) begin
        if (rx_tab[i].event_count != 0) begin
          rx_tab[i].event_count--;
          if (rx_tab[i].event_count == 0) begin
            rx_tab[i].event_count = event_reload(rx_tab[i], 1'b0);
            pending_results.push_back('{KIND_RX_TIMEOUT, 1'b0, 4'(i), ST_OK, 1'b0});
          end
        end
      end
      for (int i = 0; i < TX_ENTRIES; i++) begin
        if (tx_tab[i].inhibit_count != 0) tx_tab[i].inhibit_count--;
        if (tx_tab[i].event_count != 0) begin
          tx_tab[i].event_count--;
          if (tx_tab[i].event_count == 0) begin
            tx_tab[i].event_count = event_reload(tx_tab[i], 1'b1);
            pending_results.push_back('{KIND_TX_EVENT, 1'b1, 4'(i), ST_OK, 1'b0});
          end
        end
      end
      pending_results.push_back('{KIND_STATUS, 1'b0, 4'd0, ST_OK, 1'b1});
      return;
    end
    if (fn > FN_INHIBIT || !present || ((fn == FN_SYNC || fn == FN_INHIBIT) && !tx)) begin
      st = ST_NO_OBJECT;
    end else if (fn == FN_LOAD) begin
      if (tx) begin
        tx_tab[ent].valid = lv;
        tx_tab[ent].trans_type = ltt;
        tx_tab[ent].event_ms = lev;
        tx_tab[ent].inhibit_time = linh;
        tx_tab[ent].sync_start = lss;
        tx_tab[ent].resync = 1'b1;
        tx_tab[ent].event_count = event_reload(tx_tab[ent], 1'b1);
      end else begin
        rx_tab[ent].valid = lv;
        rx_tab[ent].trans_type = ltt;
        rx_tab[ent].event_ms = lev;
        rx_tab[ent].event_count = '0;
      end
    end else if (fn == FN_RESTART) begin
      if (tx) tx_tab[ent].event_count = event_reload(tx_tab[ent], 1'b1);
      else    rx_tab[ent].event_count = event_reload(rx_tab[ent], 1'b0);
    end else if (fn == FN_SYNC) begin
      // sync-cyclic trigger: wait for the start value on resync, then count down
      if (!tx_tab[ent].valid) st = ST_INVALID;
      else if (tx_tab[ent].trans_type == 0 || tx_tab[ent].trans_type > TT_SYNC_MAX)
        st = ST_BAD_TYPE;
      else if (tx_tab[ent].resync && tx_tab[ent].sync_start != 0 && sc != 0 &&
               tx_tab[ent].sync_start != sc)
        st = ST_NOT_TRIGGERED;
      else begin
        if (tx_tab[ent].resync) begin
          tx_tab[ent].sync_count = tx_tab[ent].trans_type;
          tx_tab[ent].resync = 1'b0;
        end
        tx_tab[ent].sync_count = tx_tab[ent].sync_count - 8'd1;
        if (tx_tab[ent].sync_count != 0) st = ST_NOT_TRIGGERED;
        else tx_tab[ent].sync_count = tx_tab[ent].trans_type;
      end
    end else begin
      // inhibit test arms the inhibit counter only for event-driven types
      if (!tx_tab[ent].valid) st = ST_INVALID;
      else if (tx_tab[ent].trans_type >= TT_EVENT_MIN) begin
        if (tx_tab[ent].inhibit_count != 0) st = ST_INHIBITED;
        else tx_tab[ent].inhibit_count = 23'((32'(tx_tab[ent].inhibit_time) * 32'd100) / d);
      end
    end
    pending_results.push_back('{KIND_STATUS, tx, ent, st, 1'b1});
  endtask

  // sends one request, updating the prediction at acceptance
  task automatic send_request(input logic [2:0] fn, input logic tx, input logic [3:0] ent,
                              input logic [7:0] sc = 8'd0, input logic lv = 1'b0,
                              input logic [7:0] ltt = 8'd0, input logic [15:0] lev = 16'd0,
                              input logic [15:0] linh = 16'd0, input logic [7:0] lss = 8'd0);
    if (burst_mode && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    func <= fn; is_transmit <= tx; entry <= ent; sync_counter <= sc;
    load_valid <= lv; load_trans_type <= ltt; load_event_ms <= lev;
    load_inhibit_100us <= linh; load_sync_start <= lss;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_request(fn, tx, ent, sc, lv, ltt, lev, linh, lss);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // drains, lets the block settle, then writes the tick period
  task automatic set_tick_period(input logic [15:0] us);
    pause_sender();
    repeat (40) @(negedge clk);
    cfg_data <= us;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    tick_us = us;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_load(input bit tx);
    logic [7:0] tt;
    case ($urandom_range(0, 3))
      0: tt = 8'($urandom_range(254, 255));
      1: tt = 8'($urandom_range(1, 5));
      2: tt = 8'($urandom_range(0, 255));
      default: tt = 8'($urandom_range(236, 242));
    endcase
    send_request(FN_LOAD, tx, 4'($urandom_range(0, 8)), 8'd0, $urandom_range(0, 7) != 0, tt,
                 ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6)),
                 ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)),
                 ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom));
  endtask

  // directed: field extremes and each special case
  task automatic test_directed();
    send_request(FN_TICK, 1'b0, 4'd0);
    send_request(FN_RESTART, 1'b0, 4'd2);
    send_request(FN_LOAD, 1'b0, 4'd0, 8'd0, 1'b1, 8'd255, 16'd2);
    send_request(FN_RESTART, 1'b0, 4'd0);
    send_request(FN_LOAD, 1'b1, 4'd1, 8'd0, 1'b1, 8'd254, 16'd1, 16'd25, 8'd0);
    send_request(FN_LOAD, 1'b1, 4'd7, 8'd0, 1'b1, 8'd255, 16'hffff, 16'hffff, 8'hff);
    send_request(FN_INHIBIT, 1'b1, 4'd1);
    send_request(FN_INHIBIT, 1'b1, 4'd1);
    send_request(FN_INHIBIT, 1'b1, 4'd7);
    send_request(FN_LOAD, 1'b1, 4'd2, 8'd0, 1'b1, 8'd2, 16'd0, 16'd0, 8'd3);
    send_request(FN_SYNC, 1'b1, 4'd2, 8'd5);
    send_request(FN_SYNC, 1'b1, 4'd2, 8'd3);
    send_request(FN_SYNC, 1'b1, 4'd2, 8'd240);
    send_request(FN_SYNC, 1'b1, 4'd3);
    send_request(FN_LOAD, 1'b1, 4'd3, 8'd0, 1'b1, 8'd241);
    send_request(FN_SYNC, 1'b1, 4'd3);
    send_request(FN_INHIBIT, 1'b1, 4'd3);
    send_request(FN_SYNC, 1'b0, 4'd0);
    send_request(FN_INHIBIT, 1'b0, 4'd0);
    send_request(FN_LOAD, 1'b1, 4'd15, 8'd0, 1'b1, 8'd255, 16'd1);
    send_request(3'd5, 1'b0, 4'd0);
    send_request(3'd7, 1'b1, 4'd15);
    send_request(FN_TICK, 1'b0, 4'd0);
    send_request(FN_TICK, 1'b0, 4'd0);
    send_request(FN_TICK, 1'b1, 4'd15, 8'hff);
  endtask

  // random: mostly loads/restarts and ticks so timers really expire
  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 20) random_load($urandom_range(0, 1));
      else if (pick < 50) send_request(FN_TICK, 1'($urandom), 4'($urandom), 8'($urandom));
      else if (pick < 60)
        send_request(FN_RESTART, 1'($urandom), 4'($urandom_range(0, 9)));
      else if (pick < 78)
        send_request(FN_SYNC, 1'($urandom_range(0, 7) != 0), 4'($urandom_range(0, 8)),
                     ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom));
      else if (pick < 93)
        send_request(FN_INHIBIT, 1'($urandom_range(0, 7) != 0), 4'($urandom_range(0, 8)));
      else
        send_request(3'($urandom), 1'($urandom), 4'($urandom), 8'($urandom), 1'($urandom),
                     8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  // receiver holds off long while the sender keeps offering requests
  task automatic test_backpressure();
    hold_off = 1'b1;
    burst_mode = 1'b0;
    fork
      test_random(12);
      begin
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end
    join
    burst_mode = 1'b1;
  endtask

  // receiver stall pattern: phases of free flow, random and heavy stalls
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk);
        if (hold_off) out_stall <= 1'b1;
        else if (mode == 0) out_stall <= 1'b0;
        else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind=%0d tx=%0d entry=%0d status=%0d last=%0d",
                   kind, is_transmit_res, entry_out, status, last);
      end else begin
        result_t exp_res;
        exp_res = pending_results.pop_front();
        if (exp_res != {kind, is_transmit_res, entry_out, status, last}) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected kind=%0d tx=%0d entry=%0d status=%0d last=%0d",
                     exp_res.kind, exp_res.tx, exp_res.ent, exp_res.st, exp_res.last);
            $display("          got      kind=%0d tx=%0d entry=%0d status=%0d last=%0d",
                     kind, is_transmit_res, entry_out, status, last);
          end
        end
      end
    end
  end

  // watchdog: cycles with no accepted request, result, cfg_valid or hold-off
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid ||
        hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    tick_us = TICK_RESET;
    for (int i = 0; i < 16; i++) begin
      rx_tab[i] = ENTRY_RESET;
      tx_tab[i] = ENTRY_RESET;
    end
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    set_tick_period(16'd1);
    test_random(80);
    test_backpressure();
    set_tick_period(16'd65535);
    test_random(40);
    set_tick_period(16'd0);
    test_random(40);
    set_tick_period(16'd1000);
    test_random(80);
    set_tick_period(16'(500 + $urandom_range(0, 1500)));
    test_random(60);
    set_tick_period(16'd3);
    test_random(60);
    pause_sender();
    repeat (200) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
